// ===== rtl/core/rcrm_pkg.sv =====
// shared types and constants for the chained range remap block
package rcrm_pkg;

  localparam int DATA_W  = 32;
  localparam int OP_W    = 2;
  localparam int STAGE_W = 3;
  localparam int SLOT_W  = 6;

  // item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_MAP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } rcrm_op_t;

  // one table entry as held in the entry memory
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] dest;
    logic [DATA_W-1:0] src;
    logic [DATA_W-1:0] span;
  } rcrm_entry_t;

  // result of the shared range compare
  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] moved;
  } rcrm_match_t;

endpackage

// ===== rtl/core/rcrm_if.sv =====
// valid/ready channel interfaces for the input and result items
interface rcrm_in_if import rcrm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [STAGE_W-1:0]   stage;
  logic [SLOT_W-1:0]    slot;
  logic [DATA_W-1:0]    dest_start;
  logic [DATA_W-1:0]    source_start;
  logic [DATA_W-1:0]    span;
  logic [DATA_W-1:0]    value;

  modport source (output valid, op, stage, slot, dest_start, source_start, span, value,
                  input ready);
  modport sink   (input valid, op, stage, slot, dest_start, source_start, span, value,
                  output ready);
endinterface

interface rcrm_out_if import rcrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] mapped;
  logic [DATA_W-1:0] running_min;

  modport source (output valid, mapped, running_min, input ready);
  modport sink   (input valid, mapped, running_min, output ready);
endinterface

// ===== rtl/core/rcrm_ram.sv =====
// generic single write port, single read port ram with registered read
module rcrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/rcrm_match.sv =====
// shared range compare and relocate unit
module rcrm_match import rcrm_pkg::*; (
  input  logic [DATA_W-1:0] cur,
  input  rcrm_entry_t       entry,
  output rcrm_match_t       res
);

  logic [DATA_W:0] diff;

  // offset into the source range, top bit is the borrow
  assign diff = {1'b0, cur} - {1'b0, entry.src};

  // half-open range hit and relocated value
  assign res.hit   = entry.valid && !diff[DATA_W] && (diff[DATA_W-1:0] < entry.span);
  assign res.moved = entry.dest + diff[DATA_W-1:0];

endmodule

// ===== rtl/core/chained_range_remap_min.sv =====
// top level: chained range remap tables with running minimum
// write and unused-op items give their result in the cycle after accept; map items
//   read and compare every entry, then push; clear items sweep all entries, then push
// no new item is taken until a map or clear item has pushed its result: the single
//   entry memory read port walks every entry of every stage once per map item
// reset: a clearing pass invalidates all entries, in_ch.ready stays low until it ends;
//   running minimum resets to all ones
module chained_range_remap_min import rcrm_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int STAGES  = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  rcrm_in_if.sink    in_ch,
  rcrm_out_if.source out_ch
);

  localparam int CELLS = STAGES * ENTRIES;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int EW_B  = $bits(rcrm_entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLR,
    S_MAP,
    S_PUSH
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [EW-1:0]     ent_r, ent_nxt;
  logic              issue_r, issue_nxt;
  logic              rv_r, rv_nxt;
  logic              eos_r, eos_nxt;
  logic              eoi_r, eoi_nxt;
  logic              found_r, found_nxt;
  logic              clr_push_r, clr_push_nxt;
  rcrm_op_t          op_r, op_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic [DATA_W-1:0] cur_r, cur_nxt;
  logic [DATA_W-1:0] min_r, min_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_mapped_r, out_mapped_nxt;
  logic [DATA_W-1:0] out_min_r, out_min_nxt;

  logic              in_fire;
  logic              out_fire;
  logic              wr_item;
  logic              sweep_we;
  logic              rd_en;
  logic [AW-1:0]     wr_idx;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  rcrm_entry_t       ram_wentry;
  logic [EW_B-1:0]   ram_rdata;
  rcrm_entry_t       rd_entry;
  rcrm_match_t       mres;
  logic [DATA_W-1:0] stage_out;

  // handshakes
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  // table entry write from a write item, ignored when out of range
  assign wr_idx  = AW'(32'(in_ch.stage) * 32'(ENTRIES) + 32'(in_ch.slot));
  assign wr_item = in_fire && (in_ch.op == OP_WRITE) &&
                   (32'(in_ch.stage) < 32'(STAGES)) && (32'(in_ch.slot) < 32'(ENTRIES));

  // memory write mux: clearing sweep or entry load
  always_comb begin
    ram_we    = sweep_we || wr_item;
    ram_waddr = sweep_we ? addr_r : wr_idx;
    if (sweep_we) begin
      ram_wentry = '0;
    end else begin
      ram_wentry.valid = 1'b1;
      ram_wentry.dest  = in_ch.dest_start;
      ram_wentry.src   = in_ch.source_start;
      ram_wentry.span  = in_ch.span;
    end
  end

  rcrm_ram #(
    .WIDTH (EW_B),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .re    (rd_en),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign rd_entry = rcrm_entry_t'(ram_rdata);

  rcrm_match u_match (
    .cur   (cur_r),
    .entry (rd_entry),
    .res   (mres)
  );

  // value leaving the current stage when its last entry is compared
  assign stage_out = found_r ? res_r : (mres.hit ? mres.moved : cur_r);

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    ent_nxt        = ent_r;
    issue_nxt      = issue_r;
    rv_nxt         = 1'b0;
    eos_nxt        = 1'b0;
    eoi_nxt        = 1'b0;
    found_nxt      = found_r;
    clr_push_nxt   = clr_push_r;
    op_nxt         = op_r;
    res_nxt        = res_r;
    cur_nxt        = cur_r;
    min_nxt        = min_r;
    out_valid_nxt  = out_valid_r;
    out_mapped_nxt = out_mapped_r;
    out_min_nxt    = out_min_r;
    sweep_we       = 1'b0;
    rd_en          = 1'b0;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt = rcrm_op_t'(in_ch.op);
          case (rcrm_op_t'(in_ch.op))
            OP_MAP: begin
              cur_nxt   = in_ch.value;
              found_nxt = 1'b0;
              addr_nxt  = '0;
              ent_nxt   = '0;
              issue_nxt = 1'b1;
              state_nxt = S_MAP;
            end
            OP_CLEAR: begin
              min_nxt      = '1;
              cur_nxt      = '0;
              addr_nxt     = '0;
              clr_push_nxt = 1'b1;
              state_nxt    = S_CLR;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_mapped_nxt = '0;
              out_min_nxt    = min_r;
            end
          endcase
        end
      end

      S_CLR: begin
        // one entry invalidated per cycle
        sweep_we = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(CELLS - 1)) begin
          addr_nxt  = '0;
          state_nxt = clr_push_r ? S_PUSH : S_IDLE;
        end
      end

      S_MAP: begin
        // issue one entry read per cycle
        if (issue_r) begin
          rd_en    = 1'b1;
          rv_nxt   = 1'b1;
          eos_nxt  = (ent_r == EW'(ENTRIES - 1));
          eoi_nxt  = (addr_r == AW'(CELLS - 1));
          addr_nxt = addr_r + 1'b1;
          ent_nxt  = (ent_r == EW'(ENTRIES - 1)) ? '0 : ent_r + 1'b1;
          if (addr_r == AW'(CELLS - 1)) begin
            issue_nxt = 1'b0;
            addr_nxt  = '0;
          end
        end
        // compare the entry read last cycle, first hit wins in a stage
        if (rv_r) begin
          if (eos_r) begin
            cur_nxt   = stage_out;
            found_nxt = 1'b0;
            if (eoi_r) begin
              state_nxt = S_PUSH;
            end
          end else if (!found_r && mres.hit) begin
            found_nxt = 1'b1;
            res_nxt   = mres.moved;
          end
        end
      end

      S_PUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_mapped_nxt = cur_r;
          out_min_nxt    = min_r;
          if ((op_r == OP_MAP) && (cur_r < min_r)) begin
            min_nxt     = cur_r;
            out_min_nxt = cur_r;
          end
          clr_push_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      addr_r      <= '0;
      ent_r       <= '0;
      issue_r     <= 1'b0;
      rv_r        <= 1'b0;
      eos_r       <= 1'b0;
      eoi_r       <= 1'b0;
      found_r     <= 1'b0;
      clr_push_r  <= 1'b0;
      op_r        <= OP_NOP;
      min_r       <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      ent_r        <= ent_nxt;
      issue_r      <= issue_nxt;
      rv_r         <= rv_nxt;
      eos_r        <= eos_nxt;
      eoi_r        <= eoi_nxt;
      found_r      <= found_nxt;
      clr_push_r   <= clr_push_nxt;
      op_r         <= op_nxt;
      res_r        <= res_nxt;
      cur_r        <= cur_nxt;
      min_r        <= min_nxt;
      out_valid_r  <= out_valid_nxt;
      out_mapped_r <= out_mapped_nxt;
      out_min_r    <= out_min_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.mapped      = out_mapped_r;
  assign out_ch.running_min = out_min_r;

  // running minimum only rises on an accepted clear item
  a_min_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !($past(in_fire) && ($past(in_ch.op) == OP_CLEAR)))
      |-> (min_r <= $past(min_r)))
    else $error("running minimum rose without a clear item");

  // entry memory is only read during a map walk
  a_read_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (state_r == S_MAP))
    else $error("entry read outside map walk");

  // no new item while a walk still has reads or compares in flight or a sweep runs
  a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!issue_r && !rv_r && !sweep_we))
    else $error("input ready during a walk or sweep");

  // a write item and the clearing sweep never collide on the write port
  a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_item && sweep_we))
    else $error("entry load during clearing sweep");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// testbench for chained_range_remap_min: directed and random items checked against a table predictor
module tb;
  import rcrm_pkg::*;

  localparam int ENTRIES      = 64;
  localparam int STAGES       = 7;
  localparam int ITEM_TARGET  = 1150;
  localparam int DRAIN_CYCLES = STAGES * ENTRIES + 16;
  localparam int WINDOW       = 4095;

  // one input item as driven on the channel
  typedef struct {
    rcrm_op_t           op;
    logic [STAGE_W-1:0] stage;
    logic [SLOT_W-1:0]  slot;
    logic [DATA_W-1:0]  dest_start;
    logic [DATA_W-1:0]  source_start;
    logic [DATA_W-1:0]  span;
    logic [DATA_W-1:0]  value;
  } remap_item_t;

  // one result item as predicted
  typedef struct {
    logic [DATA_W-1:0] mapped;
    logic [DATA_W-1:0] running_min;
  } remap_result_t;

  logic clk;
  logic rst_n = 1'b0;

  rcrm_in_if  in_ch ();
  rcrm_out_if out_ch ();

  chained_range_remap_min #(
    .ENTRIES (ENTRIES),
    .STAGES  (STAGES)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // driven channel signals
  logic        drv_valid = 1'b0;
  remap_item_t drv_pay = '{OP_NOP, '0, '0, '0, '0, '0, '0};
  logic        rcv_ready = 1'b0;

  assign in_ch.valid        = drv_valid;
  assign in_ch.op           = drv_pay.op;
  assign in_ch.stage        = drv_pay.stage;
  assign in_ch.slot         = drv_pay.slot;
  assign in_ch.dest_start   = drv_pay.dest_start;
  assign in_ch.source_start = drv_pay.source_start;
  assign in_ch.span         = drv_pay.span;
  assign in_ch.value        = drv_pay.value;
  assign out_ch.ready       = rcv_ready;

  // predictor copy of the tables and the minimum
  logic [DATA_W-1:0] tbl_dest [STAGES][ENTRIES];
  logic [DATA_W-1:0] tbl_src  [STAGES][ENTRIES];
  logic [DATA_W-1:0] tbl_span [STAGES][ENTRIES];
  bit                tbl_valid [STAGES][ENTRIES];
  logic [DATA_W-1:0] min_so_far = '1;

  remap_item_t   item_backlog[$];
  remap_result_t predicted_results[$];

  // stage 0 ranges written since the last clear, used to steer map values
  logic [DATA_W-1:0] head_src[$];
  logic [DATA_W-1:0] head_span[$];

  int mismatch_count = 0;
  int accepted_count = 0;
  int total_items    = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int run_left       = 0;
  int stall_left     = 0;
  bit rcv_next;

  // value through all stages, first matching valid entry per stage wins
  function automatic logic [DATA_W-1:0] translate_chain(logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] off;
    bit                hit;
    cur = v;
    for (int s = 0; s < STAGES; s++) begin
      hit = 1'b0;
      for (int e = 0; e < ENTRIES && !hit; e++) begin
        off = cur - tbl_src[s][e];
        if (tbl_valid[s][e] && cur >= tbl_src[s][e] && off < tbl_span[s][e]) begin
          cur = tbl_dest[s][e] + off;
          hit = 1'b1;
        end
      end
    end
    return cur;
  endfunction

  // update the predictor with one accepted item and queue its result
  task automatic apply_to_tables(remap_item_t it);
    remap_result_t r;
    r.mapped = '0;
    case (it.op)
      OP_WRITE: begin
        if (int'(it.stage) < STAGES && int'(it.slot) < ENTRIES) begin
          tbl_dest[it.stage][it.slot]  = it.dest_start;
          tbl_src[it.stage][it.slot]   = it.source_start;
          tbl_span[it.stage][it.slot]  = it.span;
          tbl_valid[it.stage][it.slot] = 1'b1;
        end
      end
      OP_MAP: begin
        r.mapped = translate_chain(it.value);
        if (r.mapped < min_so_far) min_so_far = r.mapped;
      end
      OP_CLEAR: begin
        foreach (tbl_valid[s, e]) tbl_valid[s][e] = 1'b0;
        min_so_far = '1;
      end
      default: ;
    endcase
    r.running_min = min_so_far;
    predicted_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
  endtask

  // item with every field random, op given
  function automatic remap_item_t noise_item(rcrm_op_t op);
    remap_item_t it;
    it.op           = op;
    it.stage        = STAGE_W'($urandom);
    it.slot         = SLOT_W'($urandom);
    it.dest_start   = $urandom;
    it.source_start = $urandom;
    it.span         = $urandom;
    it.value        = $urandom;
    return it;
  endfunction

  // mostly small words so chained ranges overlap, sometimes full width
  function automatic logic [DATA_W-1:0] pick_word(int hi);
    if ($urandom_range(0, 6) == 0) return $urandom;
    return DATA_W'($urandom_range(0, hi));
  endfunction

  function automatic logic [DATA_W-1:0] pick_span();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return $urandom;
      2:       return 32'hF000_0000 | DATA_W'($urandom_range(0, 32'h0FFF_FFFF));
      default: return DATA_W'($urandom_range(1, 600));
    endcase
  endfunction

  task automatic add_write(int stg, int slt, logic [DATA_W-1:0] dst,
                           logic [DATA_W-1:0] src, logic [DATA_W-1:0] spn);
    remap_item_t it;
    it              = noise_item(OP_WRITE);
    it.stage        = STAGE_W'(stg);
    it.slot         = SLOT_W'(slt);
    it.dest_start   = dst;
    it.source_start = src;
    it.span         = spn;
    item_backlog.push_back(it);
    if (stg == 0) begin
      head_src.push_back(src);
      head_span.push_back(spn);
    end
  endtask

  task automatic add_map(logic [DATA_W-1:0] v);
    remap_item_t it;
    it       = noise_item(OP_MAP);
    it.value = v;
    item_backlog.push_back(it);
  endtask

  task automatic add_plain(rcrm_op_t op);
    item_backlog.push_back(noise_item(op));
    if (op == OP_CLEAR) begin
      head_src.delete();
      head_span.delete();
    end
  endtask

  // map value: inside a known stage 0 range, on its edge, or anywhere
  function automatic logic [DATA_W-1:0] pick_map_value();
    int k;
    int r;
    r = $urandom_range(0, 9);
    if (head_src.size() > 0 && r < 7) begin
      k = $urandom_range(0, head_src.size() - 1);
      if (r == 6 || head_span[k] == 0) return head_src[k] + head_span[k] - DATA_W'(r % 2);
      return head_src[k] + ($urandom % head_span[k]);
    end
    return pick_word(WINDOW + 1000);
  endfunction

  task automatic build_stimulus();
    int n_wr;
    int n_map;
    int stg;
    int slt;
    // directed: range edges, empty range, range past the top, ignored stage,
    // lowest slot priority, rewrite, wrapping destination, unused op, clear
    add_plain(OP_CLEAR);
    add_write(0, 0, 32'd1000, 32'd50, 32'd10);
    add_map(32'd50);
    add_map(32'd59);
    add_map(32'd60);
    add_map(32'd49);
    add_write(0, 1, 32'd7, 32'd200, 32'd0);
    add_map(32'd200);
    add_write(1, 63, 32'h10, 32'hFFFF_FF00, 32'h200);
    add_map(32'hFFFF_FFFF);
    add_map(32'h0);
    add_write(7, 3, 32'd5, 32'h0, 32'hFFFF_FFFF);
    add_map(32'd123);
    add_write(2, 5, 32'd9000, 32'd300, 32'd100);
    add_write(2, 2, 32'd20, 32'd320, 32'd10);
    add_map(32'd325);
    add_map(32'd310);
    add_write(2, 2, 32'hFFFF_FFFC, 32'd320, 32'd10);
    add_map(32'd325);
    add_plain(OP_NOP);
    add_plain(OP_CLEAR);
    add_map(32'd50);
    add_plain(OP_NOP);
    add_write(6, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1);
    add_map(32'hFFFF_FFFF);

    // random: fill tables, then map through them, with some noise
    while (item_backlog.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) add_plain(OP_CLEAR);
      n_wr = $urandom_range(2, 24);
      for (int i = 0; i < n_wr; i++) begin
        stg = ($urandom_range(0, 19) == 0) ? 7 : $urandom_range(0, STAGES - 1);
        slt = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, ENTRIES - 1);
        add_write(stg, slt, pick_word(WINDOW), pick_word(WINDOW), pick_span());
      end
      n_map = $urandom_range(1, 10);
      for (int i = 0; i < n_map; i++) begin
        if ($urandom_range(0, 19) == 0) add_plain(OP_NOP);
        add_map(pick_map_value());
      end
    end
    total_items = item_backlog.size();
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: bursts of items from the backlog separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_ch.ready) begin
        apply_to_tables(drv_pay);
        accepted_count++;
      end
      if (!drv_valid || in_ch.ready) begin
        if (gap_left > 0 || item_backlog.size() == 0) begin
          if (gap_left > 0) gap_left--;
          drv_valid <= 1'b0;
        end else begin
          drv_pay   <= item_backlog.pop_front();
          drv_valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 500)
                                                     : $urandom_range(0, 6);
          end
        end
      end
    end
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    rcv_next = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && rcv_ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result, mapped", out_ch.mapped, '0);
        end else begin
          if (out_ch.mapped !== predicted_results[0].mapped)
            report_mismatch("mapped", out_ch.mapped, predicted_results[0].mapped);
          if (out_ch.running_min !== predicted_results[0].running_min)
            report_mismatch("running_min", out_ch.running_min,
                            predicted_results[0].running_min);
          void'(predicted_results.pop_front());
        end
      end
      // receiver pattern: ready runs of random length broken by stalls
      if (stall_left > 0) begin
        stall_left--;
      end else if (run_left > 0) begin
        run_left--;
        rcv_next = 1'b1;
      end else begin
        run_left   = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(20, 200);
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        rcv_next   = (stall_left == 0);
      end
    end
    rcv_ready <= rcv_next;
  end

  // main sequence
  initial begin
    build_stimulus();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted_count < total_items || predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #(50_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== chained_range_remap_min.f =====
rtl/core/rcrm_pkg.sv
rtl/core/rcrm_if.sv
rtl/core/rcrm_ram.sv
rtl/core/rcrm_match.sv
rtl/core/chained_range_remap_min.sv
dv/tb.sv
